### hw/rtl/rdf_pkg.sv
// ----------------------------------------------------------------------------
// Radix-2 DIF FFT package
// Shared sizes, register indexes, request codes and the quarter-wave cosine
// table used by the FFT core.
// ----------------------------------------------------------------------------
package rdf_pkg;

   localparam int MAX_LOG_SIZE = 10;
   localparam int MAX_POINTS   = 1 << MAX_LOG_SIZE;
   localparam int QUARTER      = MAX_POINTS / 4;
   localparam int SAMPLE_BITS  = 16;
   localparam int WORD_BITS    = 32;
   localparam int TW_BITS      = 18;
   localparam int LOG_BITS     = 4;
   localparam int CSR_IDX_BITS = 2;
   localparam int CSR_DATA_BITS = 4;
   localparam int LOG_SIZE_RESET = (10 > MAX_LOG_SIZE) ? MAX_LOG_SIZE : 10;

   localparam logic [CSR_IDX_BITS-1:0] CSR_LOG_SIZE     = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_INVERSE_MODE = 2'd1;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef logic [MAX_LOG_SIZE-1:0]     addr_type;
   typedef logic [MAX_LOG_SIZE:0]       count_type;
   typedef logic [MAX_LOG_SIZE-2:0]     rom_idx_type;
   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic signed [TW_BITS-1:0]   tw_type;
   typedef logic [16:0]                 cos_type;
   typedef cos_type                     cos_rom_type [0:QUARTER];

   typedef struct packed {
      logic start;
   } mac_ctl_type;

   typedef struct packed {
      logic done;
   } mac_sts_type;

   // Long division by shift and subtract, used only while building the table.
   function automatic longint unsigned udiv(input longint unsigned num,
                                            input longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      int              b;
      quo = 0;
      rem = 0;
      for (b = 63; b >= 0; b--) begin
         rem = (rem << 1) | ((num >> b) & 64'd1);
         if (rem >= den) begin
            rem = rem - den;
            quo = quo | (64'd1 << b);
         end
      end
      return quo;
   endfunction

   function automatic cos_type cos_q16(input longint unsigned k);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint          sum;
      longint unsigned div;
      int              n;
      x = (64'd6746518853 * k + (64'd1 << (MAX_LOG_SIZE - 1))) >> MAX_LOG_SIZE;
      x2 = (x * x + (64'd1 << 29)) >> 30;
      term = 64'd1 << 30;
      sum = longint'(term);
      for (n = 1; n <= 14; n++) begin
         div = longint'((2 * n - 1) * (2 * n));
         term = udiv((term * x2) >> 30, div);
         if ((n & 1) == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      sum = (sum + 64'sd8192) >>> 14;
      if (sum > 65535) begin
         sum = 65535;
      end
      return cos_type'(sum);
   endfunction

   function automatic cos_rom_type build_cos_rom();
      cos_rom_type rom;
      int          k;
      for (k = 0; k <= QUARTER; k++) begin
         rom[k] = (k == 0) ? cos_type'(65536) : cos_q16(longint'(k));
      end
      return rom;
   endfunction

   localparam cos_rom_type COS_ROM = build_cos_rom();

endpackage

### hw/rtl/rdf_mac.sv
// ----------------------------------------------------------------------------
// Twiddle multiply unit
// One shared 32x18 multiplier forms the rounded complex product of the
// butterfly difference and the twiddle over five steps.
// ----------------------------------------------------------------------------
module rdf_mac (
   input  logic                 clock,
   input  logic                 reset,
   input  rdf_pkg::mac_ctl_type ctl,
   output rdf_pkg::mac_sts_type sts,
   input  rdf_pkg::word_type    q_re,
   input  rdf_pkg::word_type    q_im,
   input  rdf_pkg::tw_type      tw_c,
   input  rdf_pkg::tw_type      tw_s,
   output rdf_pkg::word_type    prod_re,
   output rdf_pkg::word_type    prod_im
);

   logic [2:0]          step_ff, step_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic signed [49:0]  prod_ff, prod_in;
   logic signed [49:0]  acc_ff, acc_in;
   rdf_pkg::word_type   re_ff, re_in;
   rdf_pkg::word_type   im_ff, im_in;
   rdf_pkg::word_type   op_a;
   rdf_pkg::tw_type     op_b;
   logic signed [50:0]  total;

   always_comb begin
      op_a = q_re;
      op_b = tw_c;
      case (step_ff)
         3'd0: begin
            op_a = q_re;
            op_b = tw_c;
         end
         3'd1: begin
            op_a = q_im;
            op_b = tw_s;
         end
         3'd2: begin
            op_a = q_im;
            op_b = tw_c;
         end
         3'd3: begin
            op_a = q_re;
            op_b = tw_s;
         end
         default: begin
            op_a = q_re;
            op_b = tw_c;
         end
      endcase
   end

   always_comb begin
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      prod_in = op_a * op_b;
      acc_in  = acc_ff;
      re_in   = re_ff;
      im_in   = im_ff;
      total   = '0;
      if (ctl.start) begin
         busy_in = 1'b1;
         step_in = 3'd0;
      end else if (busy_ff) begin
         step_in = step_ff + 3'd1;
         case (step_ff)
            3'd1: acc_in = prod_ff;
            3'd2: begin
               total = 51'(acc_ff) - 51'(prod_ff) + 51'sd32768;
               re_in = total[47:16];
            end
            3'd3: acc_in = prod_ff;
            3'd4: begin
               total   = 51'(acc_ff) + 51'(prod_ff) + 51'sd32768;
               im_in   = total[47:16];
               busy_in = 1'b0;
               done_in = 1'b1;
            end
            default: acc_in = acc_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      re_ff   <= re_in;
      im_ff   <= im_in;
   end

   assign sts.done = done_ff;
   assign prod_re  = re_ff;
   assign prod_im  = im_ff;

endmodule

### hw/rtl/radix2_fft_dif.sv
// Load request: a load that completes a frame starts a transform of butterflies
// plus bit-reverse reordering (plus 1/N scaling in inverse mode).
// Read request: the result is registered through ST_RD and the output register;
// a new request is stalled until the block is back in ST_IDLE and the output is free.
// Synchronous reset clears control state; the point memory is not cleared.
// ----------------------------------------------------------------------------
// Radix-2 decimation-in-frequency FFT
// In-place complex FFT with a sequencer, point memory and a shared twiddle
// multiplier, followed by bit-reverse reordering and optional 1/N scaling.
// ----------------------------------------------------------------------------
module radix2_fft_dif (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_opcode,
   input  logic signed [rdf_pkg::SAMPLE_BITS-1:0] req_sample_re,
   input  logic signed [rdf_pkg::SAMPLE_BITS-1:0] req_sample_im,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [rdf_pkg::WORD_BITS-1:0]  rsp_point_re,
   output logic signed [rdf_pkg::WORD_BITS-1:0]  rsp_point_im,
   output logic                                  rsp_frame_ready,
   output logic                                  rsp_last_point,
   input  logic                                  csr_write,
   input  logic [rdf_pkg::CSR_IDX_BITS-1:0]      csr_index,
   input  logic [rdf_pkg::CSR_DATA_BITS-1:0]     csr_data
);

   typedef enum logic [13:0] {
      ST_IDLE   = 14'b00000000000001,
      ST_RD     = 14'b00000000000010,
      ST_BF_RD  = 14'b00000000000100,
      ST_BF_LAT = 14'b00000000001000,
      ST_BF_MUL = 14'b00000000010000,
      ST_BF_WA  = 14'b00000000100000,
      ST_BF_WB  = 14'b00000001000000,
      ST_BR_RD  = 14'b00000010000000,
      ST_BR_LAT = 14'b00000100000000,
      ST_BR_WA  = 14'b00001000000000,
      ST_BR_WB  = 14'b00010000000000,
      ST_SC_RD  = 14'b00100000000000,
      ST_SC_LAT = 14'b01000000000000,
      ST_SC_WR  = 14'b10000000000000
   } state_type;

   localparam int AW = rdf_pkg::MAX_LOG_SIZE;
   localparam int WW = rdf_pkg::WORD_BITS;

   state_type              state_ff, state_in;
   logic [rdf_pkg::LOG_BITS-1:0] log_ff, log_in;
   logic                   inv_ff, inv_in;
   rdf_pkg::addr_type      load_ff, load_in;
   rdf_pkg::addr_type      rdcnt_ff, rdcnt_in;
   logic                   sv_ff, sv_in;
   logic [rdf_pkg::LOG_BITS-1:0] lg_ff, lg_in;
   rdf_pkg::addr_type      j_ff, j_in;
   rdf_pkg::addr_type      i_ff, i_in;
   rdf_pkg::word_type      sum_re_ff, sum_re_in;
   rdf_pkg::word_type      sum_im_ff, sum_im_in;
   rdf_pkg::word_type      q_re_ff, q_re_in;
   rdf_pkg::word_type      q_im_ff, q_im_in;
   rdf_pkg::tw_type        c_ff, c_in;
   rdf_pkg::tw_type        s_ff, s_in;
   logic                   rframe_ff, rframe_in;
   logic                   rlast_ff, rlast_in;
   logic                   ovalid_ff, ovalid_in;
   rdf_pkg::word_type      ore_ff, ore_in;
   rdf_pkg::word_type      oim_ff, oim_in;
   logic                   oframe_ff, oframe_in;
   logic                   olast_ff, olast_in;

   logic [2*WW-1:0]        mem [0:rdf_pkg::MAX_POINTS-1];
   logic [2*WW-1:0]        rda_ff, rdb_ff;
   rdf_pkg::addr_type      ra, rb, wa;
   logic                   rd_en, we;
   logic [2*WW-1:0]        wd;

   rdf_pkg::mac_ctl_type   mac_ctl;
   rdf_pkg::mac_sts_type   mac_sts;
   rdf_pkg::word_type      prod_re, prod_im;

   rdf_pkg::addr_type      mask, half, o_addr, rev, rev_full, tw_t;
   rdf_pkg::count_type     i_next, n_cnt;
   rdf_pkg::rom_idx_type   c_idx, s_idx;
   logic                   c_neg;
   logic [16:0]            c_mag, s_mag;
   logic                   req_take;
   logic                   out_free;
   rdf_pkg::addr_type      lwa;
   rdf_pkg::word_type      a_re, a_im, b_re, b_im;
   logic signed [WW:0]     sc_re, sc_im;
   logic signed [WW:0]     sc_rnd;
   logic [3:0]             csr_log;

   assign mask   = rdf_pkg::addr_type'({AW{1'b1}} >> (AW - int'(log_ff)));
   assign n_cnt  = rdf_pkg::count_type'(1) << log_ff;
   assign half   = rdf_pkg::addr_type'(rdf_pkg::count_type'(1) << (lg_ff - 4'd1));
   assign o_addr = i_ff + half;
   assign i_next = rdf_pkg::count_type'(i_ff) + (rdf_pkg::count_type'(1) << lg_ff);
   assign tw_t   = j_ff << (rdf_pkg::LOG_BITS'(AW) - lg_ff);

   always_comb begin
      for (int b = 0; b < AW; b++) begin
         rev_full[b] = i_ff[AW-1-b];
      end
   end
   assign rev = rev_full >> (rdf_pkg::LOG_BITS'(AW) - log_ff);

   always_comb begin
      if (tw_t <= rdf_pkg::addr_type'(rdf_pkg::QUARTER)) begin
         c_neg = 1'b0;
         c_idx = rdf_pkg::rom_idx_type'(tw_t);
         s_idx = rdf_pkg::rom_idx_type'(rdf_pkg::addr_type'(rdf_pkg::QUARTER) - tw_t);
      end else begin
         c_neg = 1'b1;
         c_idx = rdf_pkg::rom_idx_type'(rdf_pkg::addr_type'(2 * rdf_pkg::QUARTER) - tw_t);
         s_idx = rdf_pkg::rom_idx_type'(tw_t - rdf_pkg::addr_type'(rdf_pkg::QUARTER));
      end
      c_mag = rdf_pkg::COS_ROM[c_idx];
      s_mag = rdf_pkg::COS_ROM[s_idx];
   end

   assign a_re = rda_ff[WW-1:0];
   assign a_im = rda_ff[2*WW-1:WW];
   assign b_re = rdb_ff[WW-1:0];
   assign b_im = rdb_ff[2*WW-1:WW];

   assign sc_rnd = (WW+1)'(1) << (log_ff - 4'd1);
   assign sc_re  = ($signed({a_re[WW-1], a_re}) + sc_rnd) >>> log_ff;
   assign sc_im  = ($signed({a_im[WW-1], a_im}) + sc_rnd) >>> log_ff;

   assign out_free  = !ovalid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign req_take  = req_valid && !req_stall;
   assign lwa       = sv_ff ? '0 : load_ff;
   assign mac_ctl.start = (state_ff == ST_BF_LAT);
   assign csr_log   = (csr_data < 4'd2) ? 4'd2 :
                      (csr_data > 4'(AW)) ? 4'(AW) : csr_data;

   always_comb begin
      ra    = i_ff;
      rb    = o_addr;
      rd_en = 1'b0;
      we    = 1'b0;
      wa    = i_ff;
      wd    = {sum_im_ff, sum_re_ff};
      case (state_ff)
         ST_IDLE: begin
            ra    = rdcnt_ff;
            rd_en = req_take && (req_opcode == rdf_pkg::OP_READ);
            we    = req_take && (req_opcode == rdf_pkg::OP_LOAD);
            wa    = lwa;
            wd    = {WW'(req_sample_im), WW'(req_sample_re)};
         end
         ST_BF_RD: rd_en = 1'b1;
         ST_BF_WA: we = 1'b1;
         ST_BF_WB: begin
            we = 1'b1;
            wa = o_addr;
            wd = {prod_im, prod_re};
         end
         ST_BR_RD: begin
            rb    = rev;
            rd_en = 1'b1;
         end
         ST_BR_WA: begin
            we = 1'b1;
            wd = rdb_ff;
         end
         ST_BR_WB: begin
            we = 1'b1;
            wa = rev;
            wd = rda_ff;
         end
         ST_SC_RD: rd_en = 1'b1;
         ST_SC_WR: begin
            we = 1'b1;
            wd = {sc_im[WW-1:0], sc_re[WW-1:0]};
         end
         default: rd_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      if (rd_en) begin
         rda_ff <= mem[ra];
         rdb_ff <= mem[rb];
      end
   end

   rdf_mac u_mac (
      .clock   (clock),
      .reset   (reset),
      .ctl     (mac_ctl),
      .sts     (mac_sts),
      .q_re    (q_re_ff),
      .q_im    (q_im_ff),
      .tw_c    (c_ff),
      .tw_s    (s_ff),
      .prod_re (prod_re),
      .prod_im (prod_im)
   );

   always_comb begin
      state_in  = state_ff;
      log_in    = log_ff;
      inv_in    = inv_ff;
      load_in   = load_ff;
      rdcnt_in  = rdcnt_ff;
      sv_in     = sv_ff;
      lg_in     = lg_ff;
      j_in      = j_ff;
      i_in      = i_ff;
      sum_re_in = sum_re_ff;
      sum_im_in = sum_im_ff;
      q_re_in   = q_re_ff;
      q_im_in   = q_im_ff;
      c_in      = c_ff;
      s_in      = s_ff;
      rframe_in = rframe_ff;
      rlast_in  = rlast_ff;
      ovalid_in = ovalid_ff && rsp_stall;
      ore_in    = ore_ff;
      oim_in    = oim_ff;
      oframe_in = oframe_ff;
      olast_in  = olast_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (req_opcode == rdf_pkg::OP_READ) begin
                  state_in  = ST_RD;
                  rframe_in = sv_ff;
                  rlast_in  = sv_ff && (rdcnt_ff == mask);
                  if (sv_ff) begin
                     if (rdcnt_ff == mask) begin
                        sv_in    = 1'b0;
                        rdcnt_in = '0;
                     end else begin
                        rdcnt_in = rdcnt_ff + 1'b1;
                     end
                  end
               end else begin
                  sv_in = 1'b0;
                  if (lwa == mask) begin
                     load_in  = '0;
                     rdcnt_in = '0;
                     lg_in    = log_ff;
                     j_in     = '0;
                     i_in     = '0;
                     state_in = ST_BF_RD;
                  end else begin
                     load_in = lwa + 1'b1;
                  end
               end
            end
         end
         ST_RD: begin
            ovalid_in = 1'b1;
            ore_in    = rframe_ff ? a_re : '0;
            oim_in    = rframe_ff ? a_im : '0;
            oframe_in = rframe_ff;
            olast_in  = rlast_ff;
            state_in  = ST_IDLE;
         end
         ST_BF_RD: begin
            c_in = c_neg ? -rdf_pkg::tw_type'(c_mag) : rdf_pkg::tw_type'(c_mag);
            s_in = inv_ff ? rdf_pkg::tw_type'(s_mag) : -rdf_pkg::tw_type'(s_mag);
            state_in = ST_BF_LAT;
         end
         ST_BF_LAT: begin
            sum_re_in = a_re + b_re;
            sum_im_in = a_im + b_im;
            q_re_in   = a_re - b_re;
            q_im_in   = a_im - b_im;
            state_in  = ST_BF_MUL;
         end
         ST_BF_MUL: begin
            if (mac_sts.done) begin
               state_in = ST_BF_WA;
            end
         end
         ST_BF_WA: state_in = ST_BF_WB;
         ST_BF_WB: begin
            state_in = ST_BF_RD;
            if (i_next < n_cnt) begin
               i_in = i_next[AW-1:0];
            end else if (j_ff + 1'b1 == half) begin
               j_in = '0;
               i_in = '0;
               if (lg_ff == 4'd1) begin
                  state_in = ST_BR_RD;
               end else begin
                  lg_in = lg_ff - 4'd1;
               end
            end else begin
               j_in = j_ff + 1'b1;
               i_in = j_ff + 1'b1;
            end
         end
         ST_BR_RD: begin
            if (i_ff < rev) begin
               state_in = ST_BR_LAT;
            end else if (i_ff == mask) begin
               i_in = '0;
               if (inv_ff) begin
                  state_in = ST_SC_RD;
               end else begin
                  sv_in    = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         ST_BR_LAT: state_in = ST_BR_WA;
         ST_BR_WA: state_in = ST_BR_WB;
         ST_BR_WB: begin
            i_in     = i_ff + 1'b1;
            state_in = ST_BR_RD;
         end
         ST_SC_RD: state_in = ST_SC_LAT;
         ST_SC_LAT: state_in = ST_SC_WR;
         ST_SC_WR: begin
            if (i_ff == mask) begin
               i_in     = '0;
               sv_in    = 1'b1;
               state_in = ST_IDLE;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_SC_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (csr_write) begin
         case (csr_index)
            rdf_pkg::CSR_LOG_SIZE: begin
               log_in   = csr_log;
               load_in  = '0;
               rdcnt_in = '0;
               sv_in    = 1'b0;
            end
            rdf_pkg::CSR_INVERSE_MODE: inv_in = csr_data[0];
            default: inv_in = inv_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         log_ff    <= rdf_pkg::LOG_BITS'(rdf_pkg::LOG_SIZE_RESET);
         inv_ff    <= 1'b0;
         load_ff   <= '0;
         rdcnt_ff  <= '0;
         sv_ff     <= 1'b0;
         ovalid_ff <= 1'b0;
         lg_ff     <= '0;
         j_ff      <= '0;
         i_ff      <= '0;
      end else begin
         state_ff  <= state_in;
         log_ff    <= log_in;
         inv_ff    <= inv_in;
         load_ff   <= load_in;
         rdcnt_ff  <= rdcnt_in;
         sv_ff     <= sv_in;
         ovalid_ff <= ovalid_in;
         lg_ff     <= lg_in;
         j_ff      <= j_in;
         i_ff      <= i_in;
      end
      sum_re_ff <= sum_re_in;
      sum_im_ff <= sum_im_in;
      q_re_ff   <= q_re_in;
      q_im_ff   <= q_im_in;
      c_ff      <= c_in;
      s_ff      <= s_in;
      rframe_ff <= rframe_in;
      rlast_ff  <= rlast_in;
      ore_ff    <= ore_in;
      oim_ff    <= oim_in;
      oframe_ff <= oframe_in;
      olast_ff  <= olast_in;
   end

   assign rsp_valid       = ovalid_ff;
   assign rsp_point_re    = ore_ff;
   assign rsp_point_im    = oim_ff;
   assign rsp_frame_ready = oframe_ff;
   assign rsp_last_point  = olast_ff;

endmodule
